// ----- hw/rtl/aac_pkg.sv -----
// ----------------------------------------------------------------------------
// aac_pkg: shared types and codes of the alarm arming controller
// Holds the mode codes, event codes, register indexes and the structs for
// the controller state, the settings and one result item.
// ----------------------------------------------------------------------------
`default_nettype none

package aac_pkg;

  localparam int CntW = 7;

  typedef logic [CntW-1:0] cnt_t;

  // Internal controller mode, one-hot.
  typedef enum logic [3:0] {
    MODE_DISARMED = 4'b0001,
    MODE_COUNT    = 4'b0010,
    MODE_ARMED    = 4'b0100,
    MODE_INTRUDER = 4'b1000
  } mode_t;

  // Mode codes as they appear on the result channel.
  localparam logic [1:0] MODE_CODE_DISARMED = 2'd0;
  localparam logic [1:0] MODE_CODE_COUNT    = 2'd1;
  localparam logic [1:0] MODE_CODE_ARMED    = 2'd2;
  localparam logic [1:0] MODE_CODE_INTRUDER = 2'd3;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_ENC   = 2'd1;
  localparam logic [1:0] ACT_BREAK = 2'd2;

  localparam logic [1:0] ZONE_GREEN  = 2'd0;
  localparam logic [1:0] ZONE_YELLOW = 2'd1;
  localparam logic [1:0] ZONE_RED    = 2'd2;

  localparam logic [1:0] REG_DELAY_MIN   = 2'd0;
  localparam logic [1:0] REG_DELAY_MAX   = 2'd1;
  localparam logic [1:0] REG_GREEN_FROM  = 2'd2;
  localparam logic [1:0] REG_YELLOW_FROM = 2'd3;

  localparam cnt_t DELAY_MIN_RST   = 7'd7;
  localparam cnt_t DELAY_MAX_RST   = 7'd99;
  localparam cnt_t GREEN_FROM_RST  = 7'd7;
  localparam cnt_t YELLOW_FROM_RST = 7'd4;
  localparam cnt_t DELAY_RST       = 7'd7;

  typedef struct packed {
    cnt_t delay_min;
    cnt_t delay_max;
    cnt_t green_from;
    cnt_t yellow_from;
  } aac_cfg_t;

  typedef struct packed {
    mode_t mode;
    cnt_t  delay_count;
    cnt_t  saved_delay;
    logic  armed_flag;
    logic  break_flag;
    logic  half_phase;
    logic  blink_phase;
  } aac_state_t;

  typedef struct packed {
    logic       lamp_b;
    logic       lamp_a;
    logic       alarm_on;
    logic       laser_on;
    logic [1:0] lamp_zone;
    cnt_t       count_shown;
    logic [1:0] mode;
  } aac_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/alarm_arming_controller_top.sv -----
// ----------------------------------------------------------------------------
// alarm_arming_controller_top: alarm panel arming controller
// Throughput: one item per cycle while the skid register is empty; the
// next state is formed in one pass of the step logic. An accepted item's
// result is registered in out_data_r, or, while a result is stalled, in
// the skid register, which keeps in_tready high for one more item.
// Reset: synchronous, active low; settings return to their defaults,
// the mode to disarmed and both delays to seven.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_arming_controller_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] arm_switch, [1] enc_dir, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [1:0] mode, [8:2] count_shown, [10:9] lamp_zone,
                                  // [11] laser_on, [12] alarm_on, [13] lamp_a,
                                  // [14] lamp_b, [15] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import aac_pkg::*;

  aac_cfg_t    cfg_r;
  aac_state_t  state_r, state_nxt;
  aac_result_t result;
  aac_result_t out_data_r, skid_data_r;
  logic        out_valid_r, skid_valid_r;
  logic        in_accept, out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_min   <= DELAY_MIN_RST;
      cfg_r.delay_max   <= DELAY_MAX_RST;
      cfg_r.green_from  <= GREEN_FROM_RST;
      cfg_r.yellow_from <= YELLOW_FROM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY_MIN:   cfg_r.delay_min   <= cfg_data;
        REG_DELAY_MAX:   cfg_r.delay_max   <= cfg_data;
        REG_GREEN_FROM:  cfg_r.green_from  <= cfg_data;
        REG_YELLOW_FROM: cfg_r.yellow_from <= cfg_data;
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  aac_step u_step (
    .state      (state_r),
    .cfg        (cfg_r),
    .action     (in_tuser),
    .arm_switch (in_tdata[0]),
    .enc_dir    (in_tdata[1]),
    .state_nxt  (state_nxt),
    .result     (result)
  );

  assign in_tready = ~skid_valid_r;
  assign in_accept = in_tvalid & in_tready;
  assign out_take  = out_valid_r & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode        <= MODE_DISARMED;
      state_r.delay_count <= DELAY_RST;
      state_r.saved_delay <= DELAY_RST;
      state_r.armed_flag  <= 1'b0;
      state_r.break_flag  <= 1'b0;
      state_r.half_phase  <= 1'b0;
      state_r.blink_phase <= 1'b0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end else if (in_accept) begin
      skid_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

  // The skid register only fills behind a stalled result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds an item with no result waiting");

  // A beam break is only recorded after the block has armed.
  a_break_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.break_flag |-> state_r.armed_flag)
    else $error("break flag set without armed flag");

  // Intruder is reached only through an armed entry countdown.
  a_intruder_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == MODE_INTRUDER) |-> (state_r.armed_flag && state_r.break_flag))
    else $error("intruder mode without arming and beam break");

  // A stalled result must not change under the consumer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- hw/rtl/aac_step.sv -----
// ----------------------------------------------------------------------------
// aac_step: next-state and result logic of the alarm arming controller
// Takes the current state, the settings and one event, and returns the
// state after the event together with the result item it produces.
// ----------------------------------------------------------------------------
`default_nettype none

module aac_step (
  input  aac_pkg::aac_state_t  state,
  input  aac_pkg::aac_cfg_t    cfg,
  input  logic [1:0]           action,
  input  logic                 arm_switch,
  input  logic                 enc_dir,
  output aac_pkg::aac_state_t  state_nxt,
  output aac_pkg::aac_result_t result
);
  import aac_pkg::*;

  aac_state_t  s;
  logic signed [CntW+1:0] enc_v;
  cnt_t        cnt_dec;
  logic [1:0]  mode_code;
  logic        intr;

  always_comb begin
    s       = state;
    enc_v   = '0;
    cnt_dec = '0;
    if (!arm_switch) begin
      // Leaving any active mode restores the delay saved at arming.
      if (state.mode != MODE_DISARMED) begin
        s.delay_count = state.saved_delay;
      end
      s.mode        = MODE_DISARMED;
      s.armed_flag  = 1'b0;
      s.break_flag  = 1'b0;
      s.half_phase  = 1'b0;
      s.blink_phase = 1'b0;
      if (action == ACT_ENC) begin
        enc_v = enc_dir ? $signed({2'b00, s.delay_count}) + 9'sd1
                        : $signed({2'b00, s.delay_count}) - 9'sd1;
        // The lower bound is applied last, so it wins on inverted bounds.
        if (enc_v > $signed({2'b00, cfg.delay_max})) begin
          enc_v = $signed({2'b00, cfg.delay_max});
        end
        if (enc_v < $signed({2'b00, cfg.delay_min})) begin
          enc_v = $signed({2'b00, cfg.delay_min});
        end
        s.delay_count = enc_v[CntW-1:0];
      end
    end else begin
      case (state.mode)
        MODE_DISARMED: begin
          s.saved_delay = state.delay_count;
          s.mode        = MODE_COUNT;
          s.armed_flag  = 1'b0;
          s.break_flag  = 1'b0;
          s.half_phase  = 1'b0;
        end
        MODE_COUNT: begin
          if (action == ACT_TICK) begin
            s.half_phase = ~state.half_phase;
            if (state.half_phase) begin
              cnt_dec = (state.delay_count != '0) ? state.delay_count - 7'd1 : '0;
              s.delay_count = cnt_dec;
              if (cnt_dec == '0) begin
                s.delay_count = state.saved_delay;
                if (!state.armed_flag) begin
                  s.mode       = MODE_ARMED;
                  s.armed_flag = 1'b1;
                end else begin
                  s.mode        = MODE_INTRUDER;
                  s.blink_phase = 1'b1;
                end
              end
            end
          end
        end
        MODE_ARMED: begin
          if (action == ACT_BREAK) begin
            s.break_flag = 1'b1;
            s.mode       = MODE_COUNT;
            s.half_phase = 1'b0;
          end
        end
        MODE_INTRUDER: begin
          if (action == ACT_TICK) begin
            s.blink_phase = ~state.blink_phase;
          end
        end
        default: begin
          s = state;
        end
      endcase
    end
  end

  always_comb begin
    case (s.mode)
      MODE_DISARMED: mode_code = MODE_CODE_DISARMED;
      MODE_COUNT:    mode_code = MODE_CODE_COUNT;
      MODE_ARMED:    mode_code = MODE_CODE_ARMED;
      MODE_INTRUDER: mode_code = MODE_CODE_INTRUDER;
      default:       mode_code = MODE_CODE_DISARMED;
    endcase
  end

  assign intr = (s.mode == MODE_INTRUDER);

  always_comb begin
    result             = '0;
    result.mode        = mode_code;
    result.count_shown = s.delay_count;
    if (s.mode == MODE_DISARMED || s.delay_count >= cfg.green_from) begin
      result.lamp_zone = ZONE_GREEN;
    end else if (s.delay_count >= cfg.yellow_from) begin
      result.lamp_zone = ZONE_YELLOW;
    end else begin
      result.lamp_zone = ZONE_RED;
    end
    result.laser_on = s.armed_flag;
    result.alarm_on = intr & s.blink_phase;
    result.lamp_a   = intr & s.blink_phase;
    result.lamp_b   = intr & ~s.blink_phase;
  end

  assign state_nxt = s;

endmodule

`default_nettype wire
